@@ rtl/sbm_pkg.sv @@
`default_nettype none

package sbm_pkg;

  // Fixed field widths of the command and result ports
  localparam int unsigned ItemW    = 32;
  localparam int unsigned SlotOutW = 6;
  localparam int unsigned CfgW     = 7;
  localparam int unsigned StatusW  = 2;

  // Slot count after reset
  localparam int unsigned CfgResetSlots = 64;

  // Command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  // Status codes
  localparam logic [StatusW-1:0] ST_DONE  = 2'd0;
  localparam logic [StatusW-1:0] ST_FULL  = 2'd1;
  localparam logic [StatusW-1:0] ST_EMPTY = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic accept_wr;     // pop free queue head, latch item
    logic accept_rd;     // pop occupied queue head
    logic refuse_full;   // report full, no state change
    logic refuse_empty;  // report empty, no state change
    logic wr_commit;     // append slot to occupied queue, store item
    logic rd_fetch;      // return slot to free queue, read item
    logic rd_finish;     // report read item
  } sbm_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic free_empty;
    logic used_empty;
  } sbm_stat_t;

endpackage

`default_nettype wire

@@ rtl/sbm_ram.sv @@
`default_nettype none

module sbm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ rtl/sbm_ctrl.sv @@
`default_nettype none

module sbm_ctrl
  import sbm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  logic      command_i,
  input  sbm_stat_t stat_i,
  output sbm_cmd_t  cmd_o,
  output logic      busy_o
);

  typedef enum logic [1:0] {
    StIdle,
    StWrCommit,
    StRdFetch,
    StRdFinish
  } state_e;

  state_e   state_q, state_d;
  logic     busy_q;
  sbm_cmd_t cmd;

  // Decode the next step from state and a new command
  always_comb begin
    cmd     = '0;
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          if (command_i == CMD_WRITE) begin
            if (stat_i.free_empty) begin
              cmd.refuse_full = 1'b1;
            end else begin
              cmd.accept_wr = 1'b1;
              state_d       = StWrCommit;
            end
          end else begin
            if (stat_i.used_empty) begin
              cmd.refuse_empty = 1'b1;
            end else begin
              cmd.accept_rd = 1'b1;
              state_d       = StRdFetch;
            end
          end
        end
      end
      StWrCommit: begin
        cmd.wr_commit = 1'b1;
        state_d       = StIdle;
      end
      StRdFetch: begin
        cmd.rd_fetch = 1'b1;
        state_d      = StRdFinish;
      end
      StRdFinish: begin
        cmd.rd_finish = 1'b1;
        state_d       = StIdle;
      end
    endcase
  end

  // Hold state and the busy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= (state_d != StIdle);
    end
  end

  assign cmd_o  = cmd;
  assign busy_o = busy_q;

  // At most one step per cycle
  a_one_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd))
    else $error("more than one datapath step issued");

  // A write commits in the cycle after acceptance
  a_wr_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.accept_wr |=> cmd.wr_commit)
    else $error("write accepted without commit");

  // A read is fetched and then finishes after acceptance
  a_rd_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.accept_rd |=> cmd.rd_fetch ##1 cmd.rd_finish)
    else $error("read accepted without fetch and finish");

endmodule

`default_nettype wire

@@ rtl/sbm_datapath.sv @@
`default_nettype none

module sbm_datapath
  import sbm_pkg::*;
#(
  parameter int unsigned SLOTS     = 64,
  parameter int unsigned ITEM_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sbm_cmd_t            cmd_i,
  output sbm_stat_t           stat_o,
  input  logic                cfg_we_i,
  input  logic [CfgW-1:0]     cfg_data_i,
  input  logic signed [ItemW-1:0] item_value_i,
  output logic                done_o,
  output logic signed [ItemW-1:0] read_value_o,
  output logic [SlotOutW-1:0] slot_used_o,
  output logic [StatusW-1:0]  status_o
);

  localparam int unsigned PtrW = $clog2(SLOTS);
  localparam int unsigned CntW = $clog2(SLOTS + 1);
  localparam int unsigned ResetSlots =
      (CfgResetSlots > SLOTS) ? SLOTS : CfgResetSlots;
  localparam int unsigned ResetBase = (ResetSlots == SLOTS) ? 0 : ResetSlots;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (p == PtrW'(SLOTS - 1)) ? '0 : p + PtrW'(1);
  endfunction

  // Queue pointers and counts
  logic [PtrW-1:0] free_head_q, free_tail_q, used_head_q, used_tail_q;
  logic [CntW-1:0] free_count_q, used_count_q;
  // Free queue fill tracking: entries written since the last reinit start at
  // base_q and span fill_q positions; the rest still hold their own index
  logic [PtrW-1:0] base_q;
  logic [CntW-1:0] fill_q;

  // Per-command payload
  logic [ITEM_BITS-1:0] item_q;
  logic                 hit_q;
  logic [PtrW-1:0]      head_pos_q;
  logic [PtrW-1:0]      slot_q;

  // Result registers
  logic                     done_q;
  logic [ItemW-1:0]         rd_value_q;
  logic [SlotOutW-1:0]      slot_out_q;
  logic [StatusW-1:0]       status_q;

  // Memory read data
  logic [PtrW-1:0]      free_rdata, used_rdata;
  logic [ITEM_BITS-1:0] store_rdata;

  logic [CntW-1:0]      slots_new;
  logic [PtrW-1:0]      base_new;
  logic [CntW-1:0]      head_dist;
  logic                 head_hit;
  logic [PtrW-1:0]      wr_slot;
  logic [63:0]          item_wide;
  logic [63:0]          rd_wide;

  // Clamp the slot count into 1..SLOTS
  always_comb begin
    if (cfg_data_i == '0) begin
      slots_new = CntW'(1);
    end else if (32'(cfg_data_i) > 32'(SLOTS)) begin
      slots_new = CntW'(SLOTS);
    end else begin
      slots_new = CntW'(cfg_data_i);
    end
    base_new = (slots_new == CntW'(SLOTS)) ? '0 : PtrW'(slots_new);
  end

  // Decide whether the free queue head was written since reinit
  always_comb begin
    if (free_head_q >= base_q) begin
      head_dist = CntW'(free_head_q) - CntW'(base_q);
    end else begin
      head_dist = CntW'(free_head_q) + CntW'(SLOTS) - CntW'(base_q);
    end
    head_hit = (head_dist < fill_q);
  end

  assign wr_slot   = hit_q ? free_rdata : head_pos_q;
  assign item_wide = 64'(item_value_i);
  assign rd_wide   = 64'(store_rdata);

  // Queue state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_head_q  <= '0;
      free_tail_q  <= PtrW'(ResetBase);
      free_count_q <= CntW'(ResetSlots);
      used_head_q  <= '0;
      used_tail_q  <= '0;
      used_count_q <= '0;
      base_q       <= PtrW'(ResetBase);
      fill_q       <= '0;
    end else if (cfg_we_i) begin
      free_head_q  <= '0;
      free_tail_q  <= base_new;
      free_count_q <= slots_new;
      used_head_q  <= '0;
      used_tail_q  <= '0;
      used_count_q <= '0;
      base_q       <= base_new;
      fill_q       <= '0;
    end else begin
      if (cmd_i.accept_wr) begin
        free_head_q  <= ptr_inc(free_head_q);
        free_count_q <= free_count_q - CntW'(1);
      end
      if (cmd_i.wr_commit) begin
        used_tail_q  <= ptr_inc(used_tail_q);
        used_count_q <= used_count_q + CntW'(1);
      end
      if (cmd_i.accept_rd) begin
        used_head_q  <= ptr_inc(used_head_q);
        used_count_q <= used_count_q - CntW'(1);
      end
      if (cmd_i.rd_fetch) begin
        free_tail_q  <= ptr_inc(free_tail_q);
        free_count_q <= free_count_q + CntW'(1);
        if (fill_q != CntW'(SLOTS)) begin
          fill_q <= fill_q + CntW'(1);
        end
      end
    end
  end

  // Latch per-command payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept_wr) begin
      item_q     <= item_wide[ITEM_BITS-1:0];
      hit_q      <= head_hit;
      head_pos_q <= free_head_q;
    end
    if (cmd_i.rd_fetch) begin
      slot_q <= used_rdata;
    end
  end

  // Result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.refuse_full | cmd_i.refuse_empty | cmd_i.wr_commit |
                cmd_i.rd_finish;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    priority if (cmd_i.refuse_full) begin
      rd_value_q <= '0;
      slot_out_q <= '0;
      status_q   <= ST_FULL;
    end else if (cmd_i.refuse_empty) begin
      rd_value_q <= '0;
      slot_out_q <= '0;
      status_q   <= ST_EMPTY;
    end else if (cmd_i.wr_commit) begin
      rd_value_q <= '0;
      slot_out_q <= SlotOutW'(wr_slot);
      status_q   <= ST_DONE;
    end else if (cmd_i.rd_finish) begin
      rd_value_q <= rd_wide[ItemW-1:0];
      slot_out_q <= SlotOutW'(slot_q);
      status_q   <= ST_DONE;
    end
  end

  // Free slot queue
  sbm_ram #(
    .Width (PtrW),
    .Depth (SLOTS)
  ) u_free_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.rd_fetch),
    .waddr_i (free_tail_q),
    .wdata_i (used_rdata),
    .re_i    (cmd_i.accept_wr),
    .raddr_i (free_head_q),
    .rdata_o (free_rdata)
  );

  // Occupied slot queue
  sbm_ram #(
    .Width (PtrW),
    .Depth (SLOTS)
  ) u_used_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_commit),
    .waddr_i (used_tail_q),
    .wdata_i (wr_slot),
    .re_i    (cmd_i.accept_rd),
    .raddr_i (used_head_q),
    .rdata_o (used_rdata)
  );

  // Item store
  sbm_ram #(
    .Width (ITEM_BITS),
    .Depth (SLOTS)
  ) u_store_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_commit),
    .waddr_i (wr_slot),
    .wdata_i (item_q),
    .re_i    (cmd_i.rd_fetch),
    .raddr_i (used_rdata),
    .rdata_o (store_rdata)
  );

  assign stat_o.free_empty = (free_count_q == '0);
  assign stat_o.used_empty = (used_count_q == '0);

  assign done_o       = done_q;
  assign read_value_o = rd_value_q;
  assign slot_used_o  = slot_out_q;
  assign status_o     = status_q;

  // Slots are never created: both queues together hold at most SLOTS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(free_count_q) + 32'(used_count_q)) <= 32'(SLOTS))
    else $error("queue counts exceed slot count");

  // Fill tracking never passes the queue depth
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CntW'(SLOTS))
    else $error("free queue fill count out of range");

  // A successful result leaves a good status on the next cycle
  a_done_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.wr_commit || cmd_i.rd_finish) |=> (done_q && status_q == ST_DONE))
    else $error("completed command without done status");

endmodule

`default_nettype wire

@@ rtl/slot_buffer_manager.sv @@
// Write command: accept, commit, registered strobe; a new command is taken only in idle.
// Read command: accept, fetch, finish, registered strobe; the fetch and finish steps are
//   set by the occupied-queue read followed by the item-store read (registered RAM ports).
// Refused command (full or empty): strobe in the cycle after acceptance; one per cycle.
// Results cannot be held off; busy covers the queue lookups. Reset is asynchronous and
//   takes effect at once with 64 (at most SLOTS) free slots; no clearing pass is needed.
`default_nettype none

module slot_buffer_manager
  import sbm_pkg::*;
#(
  parameter int unsigned SLOTS     = 64,
  parameter int unsigned ITEM_BITS = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic                    command_i,
  input  logic signed [ItemW-1:0] item_value_i,
  output logic                    done_o,
  output logic signed [ItemW-1:0] read_value_o,
  output logic [SlotOutW-1:0]     slot_used_o,
  output logic [StatusW-1:0]      status_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CfgW-1:0]         cfg_data_i
);

  sbm_cmd_t  cmd;
  sbm_stat_t stat;
  logic      busy_int;

  // Take slot-count writes whenever no command is in flight or being issued
  assign cfg_ready_o = !busy_int && !start;
  assign busy        = busy_int;

  sbm_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .command_i (command_i),
    .stat_i    (stat),
    .cmd_o     (cmd),
    .busy_o    (busy_int)
  );

  sbm_datapath #(
    .SLOTS     (SLOTS),
    .ITEM_BITS (ITEM_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .item_value_i (item_value_i),
    .done_o       (done_o),
    .read_value_o (read_value_o),
    .slot_used_o  (slot_used_o),
    .status_o     (status_o)
  );

endmodule

`default_nettype wire
